>>> sv/config_line_tokenizer_defines.svh
// Assertion macros of the tokenizer RTL.
`ifndef CONFIG_LINE_TOKENIZER_DEFINES_SVH
`define CONFIG_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is high.
`define CLT_ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: tokenizer check failed");

// Next-cycle implication, sampled on the rising edge, off while reset is high.
`define CLT_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: tokenizer check failed");

`endif

>>> sv/clt_pkg.sv
// Shared types, character codes and helpers of the line tokenizer.
`default_nettype none

package clt_pkg;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  localparam int OPQ_DEPTH  = 4;
  localparam int RESQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_EOF
  } op_kind_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_END    = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_EOF    = 2'd3
  } kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  chr;
    logic [15:0] line;
    logic        last;
  } op_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  token_byte;
    logic        starts_token;
    logic        unterminated;
    logic [15:0] line_number;
    logic        last_of_run;
  } res_t;

  function automatic logic is_white(input logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

endpackage

`default_nettype wire

>>> sv/clt_fifo.sv
// Small first-in first-out queue of packed beats.
`default_nettype none

module clt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/clt_front.sv
// Front end: takes input beats, counts lines, holds whitespace and issues lexer ops.
`default_nettype none

module clt_front #(
  parameter int SPACE_HOLD_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          func,
  input  logic [7:0]    text_byte,
  output logic          op_push,
  output clt_pkg::op_t  op_out,
  input  logic          op_full
);

  import clt_pkg::*;

  localparam int CNT_W = $clog2(SPACE_HOLD_DEPTH + 1);
  localparam int IDX_W = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SPACE_HOLD_DEPTH);

  typedef enum logic [1:0] {
    F_IDLE,
    F_REPLAY,
    F_FINAL
  } fstate_t;

  fstate_t          state;
  logic [7:0]       space_store [SPACE_HOLD_DEPTH];
  logic [CNT_W-1:0] space_count;
  logic [IDX_W-1:0] rep_idx;
  logic [7:0]       pend_byte;
  logic             pend_white;
  logic [15:0]      line_count;
  logic             line_fresh;

  logic             accept;
  logic             in_white;
  logic             in_lf;
  logic             rep_last;
  logic [15:0]      line_upd;
  logic [7:0]       rep_byte;

  assign full     = (state != F_IDLE) || op_full;
  assign accept   = push && !full;
  assign in_lf    = (text_byte == CH_LF);
  assign in_white = is_white(text_byte);
  // a text beat first after reset or a line end opens the next line, up to LINE_MAX
  assign line_upd = (line_fresh && !func && line_count != LINE_MAX) ?
                    line_count + 16'd1 : line_count;
  assign rep_byte = space_store[rep_idx];
  assign rep_last = ((CNT_W'(rep_idx) + CNT_W'(1)) == space_count);

  always_comb begin
    op_push = 1'b0;
    op_out  = '{kind: OP_CHAR, chr: text_byte, line: line_upd, last: 1'b1};
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (func) begin
            op_push     = 1'b1;
            op_out.kind = OP_EOF;
          end else if (in_lf) begin
            op_push     = 1'b1;
            op_out.kind = OP_NEWLINE;
          end else if (!in_white && space_count == '0) begin
            op_push = 1'b1;
          end
        end
      end
      F_REPLAY: begin
        op_push     = !op_full;
        op_out.chr  = rep_byte;
        op_out.line = line_count;
        op_out.last = pend_white && rep_last;
      end
      F_FINAL: begin
        op_push     = !op_full;
        op_out.chr  = pend_byte;
        op_out.line = line_count;
      end
      default: begin
        op_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      space_count <= '0;
      line_count  <= '0;
      line_fresh  <= 1'b1;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            line_count <= line_upd;
            if (func || in_lf) begin
              space_count <= '0;
              line_fresh  <= 1'b1;
            end else begin
              line_fresh <= 1'b0;
              if (in_white && space_count != CNT_FULL) begin
                space_store[space_count[IDX_W-1:0]] <= text_byte;
                space_count <= space_count + CNT_W'(1);
              end else if (space_count != '0) begin
                // replay held whitespace before this beat
                state      <= F_REPLAY;
                rep_idx    <= '0;
                pend_byte  <= text_byte;
                pend_white <= in_white;
              end
            end
          end
        end
        F_REPLAY: begin
          if (!op_full) begin
            if (rep_last) begin
              if (pend_white) begin
                space_store[0] <= pend_byte;
                space_count    <= CNT_W'(1);
                state          <= F_IDLE;
              end else begin
                state <= F_FINAL;
              end
            end else begin
              rep_idx <= rep_idx + IDX_W'(1);
            end
          end
        end
        F_FINAL: begin
          if (!op_full) begin
            space_count <= '0;
            state       <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/clt_back.sv
// Back end: runs the lexer on queued ops and emits result beats through a hold stage.
`default_nettype none

module clt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  clt_pkg::op_t  op,
  output logic          op_pop,
  output logic          res_push,
  output clt_pkg::res_t res,
  input  logic          res_full
);

  import clt_pkg::*;

  typedef enum logic [2:0] {
    M_BETWEEN,
    M_ORDINARY,
    M_ZERO,
    M_ZERO_T,
    M_QUOTED,
    M_COMMENT
  } mode_t;

  mode_t       mode;
  mode_t       mode_next;
  logic        at_line_start;
  logic        at_line_start_next;
  logic [7:0]  quote_delim;
  logic [7:0]  quote_delim_next;
  logic [1:0]  len_sat;
  logic [1:0]  len_sat_next;
  logic        colon_held;
  logic        colon_held_next;

  logic [1:0]  sub;
  logic        h_valid;
  logic        h_fin;
  res_t        h_res;

  logic [7:0]  c;
  logic [15:0] ln;
  logic        c_blank;
  logic        c_quote;
  logic        ord_path;
  logic        pre_char;
  logic        do_finish;
  logic        fin_unterm;
  logic        colon_flush;
  logic        ord_char;
  logic        do_start;
  logic        start_col0;
  logic        start_emit;
  logic        do_eof;

  res_t        slots [4];
  logic [2:0]  n_res;
  logic        has_res;
  logic        op_done;
  logic        back_go;
  logic        close;
  logic        new_res;
  logic        res_last;

  function automatic res_t mk(input kind_t k, input logic [7:0] b, input logic s,
                              input logic u, input logic [15:0] line);
    res_t r;
    r.kind         = k;
    r.token_byte   = (k == KIND_CHAR) ? b : 8'd0;
    r.starts_token = s;
    r.unterminated = u;
    r.line_number  = line;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign c       = op.chr;
  assign ln      = op.line;
  assign c_blank = (c == CH_SPACE) || (c == CH_TAB);
  assign c_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);

  // decode one op against the lexer state
  always_comb begin
    ord_path           = 1'b0;
    pre_char           = 1'b0;
    do_finish          = 1'b0;
    fin_unterm         = 1'b0;
    colon_flush        = 1'b0;
    ord_char           = 1'b0;
    do_start           = 1'b0;
    start_col0         = 1'b0;
    do_eof             = 1'b0;
    mode_next          = mode;
    at_line_start_next = at_line_start;
    quote_delim_next   = quote_delim;
    len_sat_next       = len_sat;
    colon_held_next    = colon_held;

    case (op.kind)
      OP_CHAR: begin
        at_line_start_next = 1'b0;
        case (mode)
          M_ORDINARY: begin
            ord_path = 1'b1;
          end
          M_ZERO: begin
            if (c == CH_T) begin
              pre_char     = 1'b1;
              mode_next    = M_ZERO_T;
              len_sat_next = 2'd2;
            end else begin
              ord_path = 1'b1;
            end
          end
          M_ZERO_T: begin
            pre_char = 1'b1;
          end
          M_QUOTED: begin
            pre_char     = 1'b1;
            len_sat_next = 2'd2;
            do_finish    = (c == quote_delim);
          end
          M_COMMENT: begin
            pre_char = 1'b0;
          end
          default: begin
            do_start   = 1'b1;
            start_col0 = at_line_start;
          end
        endcase

        if (ord_path) begin
          mode_next = M_ORDINARY;
          if (is_white(c)) begin
            do_finish = 1'b1;
            do_start  = 1'b1;
          end else begin
            colon_flush     = colon_held;
            colon_held_next = (c == CH_COLON) && (len_sat != 2'd0);
            ord_char        = !((c == CH_COLON) && (len_sat != 2'd0));
            len_sat_next    = 2'd2;
          end
        end
      end
      OP_NEWLINE, OP_EOF: begin
        do_finish          = mode inside {M_ORDINARY, M_ZERO, M_ZERO_T, M_QUOTED};
        fin_unterm         = (mode == M_QUOTED);
        do_eof             = (op.kind == OP_EOF);
        at_line_start_next = 1'b1;
      end
      default: begin
        do_eof = 1'b0;
      end
    endcase

    if (do_finish || op.kind != OP_CHAR) begin
      mode_next        = M_BETWEEN;
      colon_held_next  = 1'b0;
      len_sat_next     = 2'd0;
      quote_delim_next = 8'd0;
    end

    if (do_start) begin
      if (c_blank) begin
        mode_next = M_BETWEEN;
      end else if (c == CH_HASH) begin
        mode_next = M_COMMENT;
      end else begin
        len_sat_next = 2'd1;
        if (c_quote) begin
          mode_next        = M_QUOTED;
          quote_delim_next = c;
        end else if (c == CH_ZERO) begin
          mode_next = M_ZERO;
        end else begin
          mode_next = M_ORDINARY;
        end
      end
    end
  end

  assign start_emit = do_start && !c_blank && (c != CH_HASH);

  // list the result beats of the op in order
  always_comb begin
    n_res = 3'd0;
    for (int i = 0; i < 4; i++) begin
      slots[i] = '0;
    end
    if (pre_char) begin
      slots[n_res[1:0]] = mk(KIND_CHAR, c, 1'b0, 1'b0, ln);
      n_res = n_res + 3'd1;
    end
    if (do_finish) begin
      if (colon_held) begin
        // split a trailing colon off as a token of its own
        slots[n_res[1:0]] = mk(KIND_END, 8'd0, 1'b0, 1'b0, ln);
        n_res = n_res + 3'd1;
        slots[n_res[1:0]] = mk(KIND_CHAR, CH_COLON, 1'b1, 1'b0, ln);
        n_res = n_res + 3'd1;
        slots[n_res[1:0]] = mk(KIND_END, 8'd0, 1'b0, 1'b0, ln);
        n_res = n_res + 3'd1;
      end else begin
        slots[n_res[1:0]] = mk(KIND_END, 8'd0, 1'b0, fin_unterm, ln);
        n_res = n_res + 3'd1;
      end
    end
    if (colon_flush) begin
      slots[n_res[1:0]] = mk(KIND_CHAR, CH_COLON, 1'b0, 1'b0, ln);
      n_res = n_res + 3'd1;
    end
    if (ord_char) begin
      slots[n_res[1:0]] = mk(KIND_CHAR, c, 1'b0, 1'b0, ln);
      n_res = n_res + 3'd1;
    end
    if (start_emit && start_col0) begin
      slots[n_res[1:0]] = mk(KIND_RECORD, 8'd0, 1'b0, 1'b0, ln);
      n_res = n_res + 3'd1;
    end
    if (start_emit) begin
      slots[n_res[1:0]] = mk(KIND_CHAR, c, 1'b1, 1'b0, ln);
      n_res = n_res + 3'd1;
    end
    if (do_eof) begin
      slots[n_res[1:0]] = mk(KIND_EOF, 8'd0, 1'b0, 1'b0, ln);
      n_res = n_res + 3'd1;
    end
  end

  assign has_res  = (n_res != 3'd0);
  assign op_done  = !has_res || ((3'(sub) + 3'd1) == n_res);
  assign back_go  = op_valid && (!h_valid || !res_full);
  assign close    = back_go && op_done && op.last;
  assign new_res  = back_go && has_res;
  assign op_pop   = back_go && op_done;
  // the held beat goes out once a newer beat replaces it or its run is closed
  assign res_push = h_valid && !res_full && (h_fin || new_res || close);
  assign res_last = h_fin || (close && !new_res);

  always_comb begin
    res             = h_res;
    res.last_of_run = res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_BETWEEN;
      at_line_start <= 1'b1;
      quote_delim   <= 8'd0;
      len_sat       <= 2'd0;
      colon_held    <= 1'b0;
      sub           <= 2'd0;
      h_valid       <= 1'b0;
      h_fin         <= 1'b0;
    end else begin
      if (back_go) begin
        sub <= op_done ? 2'd0 : sub + 2'd1;
      end
      if (back_go && op_done) begin
        mode          <= mode_next;
        at_line_start <= at_line_start_next;
        quote_delim   <= quote_delim_next;
        len_sat       <= len_sat_next;
        colon_held    <= colon_held_next;
      end
      if (new_res) begin
        h_valid <= 1'b1;
        h_fin   <= close;
        h_res   <= slots[sub];
      end else if (res_push) begin
        h_valid <= 1'b0;
        h_fin   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/config_line_tokenizer.sv
// Top level of the streaming tokenizer for line-oriented control text.
// Input side is a queue: a beat (func, text_byte) is taken when push is high
// and full is low. func = 1 marks end of input and closes the current line.
// Result side is a queue too: while empty is low the oldest result beat
// (kind, token_byte, starts_token, unterminated, line_number, last_of_run)
// stands on the ports and pop takes it.
// The front end holds up to SPACE_HOLD_DEPTH whitespace bytes of a line. A
// byte that ends a whitespace run is taken, the held bytes are replayed and
// then the byte is issued (whitespace that meets a full store starts a new
// held run instead); any other byte is issued as it is taken. The back end
// moves one result beat a cycle while an op is queued, unless a beat waits
// in the hold stage while the result queue is full; an op with no result is
// popped without a beat. An op queue of four entries sits between the ends.
// A byte's results pass the op queue, the hold stage and the result queue in
// turn; a run's last beat stays held until the run is known done.
// Reset puts the lexer between tokens at the start of a line with a line
// count of zero and empties both queues. When the receiver stops popping,
// the result queue, hold stage and op queue fill in turn and full rises.
`default_nettype none
`include "config_line_tokenizer_defines.svh"

module config_line_tokenizer #(
  parameter int SPACE_HOLD_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [7:0]  text_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  token_byte,
  output logic        starts_token,
  output logic        unterminated,
  output logic [15:0] line_number,
  output logic        last_of_run
);

  import clt_pkg::*;

  localparam int OP_W  = $bits(op_t);
  localparam int RES_W = $bits(res_t);

  op_t              op_in;
  op_t              op_head;
  logic [OP_W-1:0]  op_head_bits;
  logic             op_push;
  logic             op_full;
  logic             op_empty;
  logic             op_pop;

  res_t             res_in;
  res_t             res_head;
  logic [RES_W-1:0] res_head_bits;
  logic             res_push;
  logic             res_full;

  clt_front #(
    .SPACE_HOLD_DEPTH(SPACE_HOLD_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .func     (func),
    .text_byte(text_byte),
    .op_push  (op_push),
    .op_out   (op_in),
    .op_full  (op_full)
  );

  clt_fifo #(
    .WIDTH(OP_W),
    .DEPTH(OPQ_DEPTH)
  ) u_op_q (
    .clk  (clk),
    .rst  (rst),
    .push (op_push),
    .wdata(op_in),
    .full (op_full),
    .pop  (op_pop),
    .rdata(op_head_bits),
    .empty(op_empty)
  );

  assign op_head = op_t'(op_head_bits);

  clt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .op_valid(!op_empty),
    .op      (op_head),
    .op_pop  (op_pop),
    .res_push(res_push),
    .res     (res_in),
    .res_full(res_full)
  );

  clt_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RESQ_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_head_bits),
    .empty(empty)
  );

  assign res_head     = res_t'(res_head_bits);
  assign kind         = res_head.kind;
  assign token_byte   = res_head.token_byte;
  assign starts_token = res_head.starts_token;
  assign unterminated = res_head.unterminated;
  assign line_number  = res_head.line_number;
  assign last_of_run  = res_head.last_of_run;

  `CLT_ASSERT_IMPL(a_op_q_no_overrun, clk, rst, op_push, !op_full)
  `CLT_ASSERT_IMPL(a_res_q_no_overrun, clk, rst, res_push, !res_full)
  `CLT_ASSERT_IMPL(a_eof_closes_run, clk, rst, !empty && kind == KIND_EOF, last_of_run)
  `CLT_ASSERT_IMPL(a_byte_only_on_char, clk, rst, !empty && kind != KIND_CHAR, token_byte == 8'd0)
  `CLT_ASSERT_NEXT(a_eof_op_queued, clk, rst, push && !full && func, !op_empty)

endmodule

`default_nettype wire
